### hw/rtl/gpt_pkg.sv
package gpt_pkg;

  // Access codes carried by the operation field
  localparam logic OpTrigger = 1'b0;
  localparam logic OpRead    = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CfgSwapPairs    = 2'd0;
  localparam logic [1:0] CfgInvertValues = 2'd1;
  localparam logic [1:0] CfgMarginLeft   = 2'd2;
  localparam logic [1:0] CfgMarginTop    = 2'd3;

  localparam int StampWidth = 48;
  localparam int PosWidth   = 10;
  localparam int ValWidth   = 9;
  localparam int NumPaddles = 4;

  localparam logic [7:0]          XScale        = 8'd117;
  localparam logic [7:0]          YScale        = 8'd170;
  localparam logic [ValWidth-1:0] PadMaxValue   = 9'd280;
  localparam logic [ValWidth-1:0] PadFull       = 9'd255;
  localparam logic [3:0]          CyclesPerStep = 4'd11;
  localparam logic [7:0]          PadRunning    = 8'h80;
  localparam logic [7:0]          PadDone       = 8'h00;

  typedef logic [StampWidth-1:0] stamp_t;
  typedef logic [PosWidth-1:0]   pos_t;
  typedef logic [ValWidth-1:0]   pad_val_t;
  typedef pad_val_t              pad_array_t [NumPaddles];

  typedef struct packed {
    logic swap_pairs;
    logic invert_values;
  } read_cfg_t;

endpackage

### hw/rtl/gpt_if.sv
interface gpt_in_if;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [47:0]             cycle_stamp;
  logic [1:0]              paddle_index;
  logic [9:0]              mouse_x;
  logic [9:0]              mouse_y;

  modport source (output valid, operation, cycle_stamp, paddle_index, mouse_x, mouse_y,
                  input ready);
  modport sink   (input valid, operation, cycle_stamp, paddle_index, mouse_x, mouse_y,
                  output ready);
endinterface

interface gpt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

interface gpt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/gpt_axis_scale.sv
module gpt_axis_scale (
  input  gpt_pkg::pos_t     pos,
  input  gpt_pkg::pos_t     margin,
  input  logic [7:0]        factor,
  output gpt_pkg::pad_val_t value
);
  import gpt_pkg::*;

  logic [PosWidth-1:0]   offset;
  logic [PosWidth+7:0]   product;
  logic [PosWidth-1:0]   scaled;

  // Offset is zero when the position sits at or left of / above the margin
  assign offset  = (pos > margin) ? pos - margin : '0;
  assign product = offset * factor;
  assign scaled  = product[PosWidth+7:8];
  assign value   = (scaled > {1'b0, PadMaxValue}) ? PadMaxValue : scaled[ValWidth-1:0];

endmodule

### hw/rtl/gpt_read_eval.sv
module gpt_read_eval (
  input  gpt_pkg::read_cfg_t  cfg,
  input  logic [1:0]          paddle_index,
  input  gpt_pkg::stamp_t     cycle_stamp,
  input  gpt_pkg::stamp_t     trigger_time,
  input  gpt_pkg::pad_array_t pad_values,
  output logic [7:0]          read_data
);
  import gpt_pkg::*;

  logic [1:0]                 sel;
  pad_val_t                   raw;
  logic signed [ValWidth:0]   val;      // -25 .. 280
  logic signed [ValWidth+4:0] span;     // val * 11
  logic signed [StampWidth+1:0] end_time;
  logic signed [StampWidth+1:0] now;

  assign sel  = paddle_index ^ {1'b0, cfg.swap_pairs};
  assign raw  = pad_values[sel];
  assign val  = cfg.invert_values ? $signed({1'b0, PadFull}) - $signed({1'b0, raw})
                                  : $signed({1'b0, raw});
  assign span = val * $signed({1'b0, CyclesPerStep});

  assign end_time = $signed({2'b00, trigger_time}) + (StampWidth+2)'(span);
  assign now      = $signed({2'b00, cycle_stamp});

  assign read_data = (now < end_time) ? PadRunning : PadDone;

endmodule

### hw/rtl/game_paddle_timer.sv
// Game paddle timers. A trigger item latches its cycle stamp and loads the four paddle
// values (paddle 0 from mouse X, paddle 1 from mouse Y, both less their margins, scaled by
// 117/256 and 170/256 and clamped to 280; paddles 2 and 3 to 255); it returns nothing. A
// read item picks a paddle (bit 0 optionally flipped), optionally inverts it to 255 minus
// the value, and returns 0x80 while its stamp is below trigger time + value * 11, else 0x00.
// Rate: one item per cycle unless a read is stalled. A read passes one input register, then
// the scale / compare logic feeding the result register. Trigger state updates as the item
// leaves the input register, so a read right behind a trigger sees the new values.
// Configuration writes are always accepted; write them only while the block is idle.
module game_paddle_timer (
  input  logic clk,
  input  logic rst,
  gpt_in_if.sink    in_ch,
  gpt_out_if.source out_ch,
  gpt_cfg_if.sink   cfg
);
  import gpt_pkg::*;

  // configuration
  read_cfg_t read_cfg;
  pos_t      margin_left;
  pos_t      margin_top;

  // architectural state
  stamp_t     trigger_time;
  pad_array_t pad_values;

  // input register
  logic       s1_valid;
  logic       s1_op;
  stamp_t     s1_stamp;
  logic [1:0] s1_idx;
  pos_t       s1_mx;
  pos_t       s1_my;

  // result register
  logic       out_valid;
  logic [7:0] out_data;

  logic       s1_adv;
  pad_val_t   pad0_next;
  pad_val_t   pad1_next;
  logic [7:0] read_data_next;

  // A trigger never waits on the output side; a read needs a free or draining result slot
  assign s1_adv     = s1_valid && ((s1_op == OpTrigger) || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign cfg.ready  = 1'b1;

  assign out_ch.valid     = out_valid;
  assign out_ch.read_data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_cfg    <= '0;
      margin_left <= '0;
      margin_top  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgSwapPairs:    read_cfg.swap_pairs    <= cfg.data[0];
        CfgInvertValues: read_cfg.invert_values <= cfg.data[0];
        CfgMarginLeft:   margin_left            <= cfg.data;
        CfgMarginTop:    margin_top             <= cfg.data;
        default: ;
      endcase
    end
  end

  gpt_axis_scale u_scale_x (
    .pos    (s1_mx),
    .margin (margin_left),
    .factor (XScale),
    .value  (pad0_next)
  );

  gpt_axis_scale u_scale_y (
    .pos    (s1_my),
    .margin (margin_top),
    .factor (YScale),
    .value  (pad1_next)
  );

  gpt_read_eval u_read (
    .cfg          (read_cfg),
    .paddle_index (s1_idx),
    .cycle_stamp  (s1_stamp),
    .trigger_time (trigger_time),
    .pad_values   (pad_values),
    .read_data    (read_data_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_op    <= in_ch.operation;
      s1_stamp <= in_ch.cycle_stamp;
      s1_idx   <= in_ch.paddle_index;
      s1_mx    <= in_ch.mouse_x;
      s1_my    <= in_ch.mouse_y;
    end
  end

  // trigger state
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_time <= '0;
      for (int i = 0; i < NumPaddles; i++) begin
        pad_values[i] <= '0;
      end
    end else if (s1_adv && (s1_op == OpTrigger)) begin
      trigger_time  <= s1_stamp;
      pad_values[0] <= pad0_next;
      pad_values[1] <= pad1_next;
      pad_values[2] <= PadFull;
      pad_values[3] <= PadFull;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && (s1_op == OpRead)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && (s1_op == OpRead)) begin
      out_data <= read_data_next;
    end
  end

  // a read leaving the input register always lands in the result register
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_op == OpRead) |=> out_valid)
    else $error("read item lost between input and result register");

  // a stalled input register keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_stamp) && $stable(s1_op))
    else $error("input register dropped a stalled item");

  // mouse-driven paddles never exceed the clamp
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (pad_values[0] <= PadMaxValue) && (pad_values[1] <= PadMaxValue))
    else $error("paddle value above clamp");

  // fixed paddles hold either their reset value or full scale
  a_fixed_pads: assert property (@(posedge clk) disable iff (rst)
    ((pad_values[2] == '0) || (pad_values[2] == PadFull)) &&
    ((pad_values[3] == '0) || (pad_values[3] == PadFull)))
    else $error("paddle 2 or 3 holds an unexpected value");

endmodule

### test/paddle_check.sv
module paddle_check (
  input  logic clk,
  input  logic rst,
  gpt_in_if    in_ch,
  gpt_out_if   out_ch,
  gpt_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import gpt_pkg::*;

  // Shadow copy of the block's registers and timer state
  logic       swap_cfg;
  logic       invert_cfg;
  pos_t       margin_x;
  pos_t       margin_y;
  stamp_t     trig_stamp;
  pad_val_t   paddle [NumPaddles];
  logic [7:0] expected_reads [$];

  function automatic pad_val_t paddle_level(pos_t pos, pos_t margin, logic [7:0] factor);
    int level;
    level = 0;
    if (pos > margin) level = (int'(pos - margin) * int'(factor)) >> 8;
    if (level > int'(PadMaxValue)) level = int'(PadMaxValue);
    return pad_val_t'(level);
  endfunction

  // Signed 64-bit deadline compare; inverted values above 255 go negative.
  function automatic logic [7:0] timer_level(logic [1:0] idx, stamp_t stamp);
    logic [1:0] sel;
    longint     val;
    longint     deadline;
    sel = swap_cfg ? (idx ^ 2'b01) : idx;
    val = longint'(paddle[sel]);
    if (invert_cfg) val = longint'(PadFull) - val;
    deadline = longint'(trig_stamp) + val * longint'(CyclesPerStep);
    return (longint'(stamp) < deadline) ? PadRunning : PadDone;
  endfunction

  task automatic report(string what);
    $display("%0t ns: read_data check failed: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    logic [7:0] want;
    if (rst) begin
      swap_cfg   = 1'b0;
      invert_cfg = 1'b0;
      margin_x   = '0;
      margin_y   = '0;
      trig_stamp = '0;
      for (int i = 0; i < NumPaddles; i++) paddle[i] = '0;
      expected_reads.delete();
    end else begin
      // results first, so a stray one never matches a read taken this edge
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reads.size() == 0) begin
          report($sformatf("got %h with no read pending", out_ch.read_data));
        end else begin
          want = expected_reads.pop_front();
          if (out_ch.read_data !== want)
            report($sformatf("got %h expected %h", out_ch.read_data, want));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CfgSwapPairs:    swap_cfg   = cfg.data[0];
          CfgInvertValues: invert_cfg = cfg.data[0];
          CfgMarginLeft:   margin_x   = cfg.data;
          CfgMarginTop:    margin_y   = cfg.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OpTrigger) begin
          trig_stamp = in_ch.cycle_stamp;
          paddle[0]  = paddle_level(in_ch.mouse_x, margin_x, XScale);
          paddle[1]  = paddle_level(in_ch.mouse_y, margin_y, YScale);
          paddle[2]  = PadFull;
          paddle[3]  = PadFull;
        end else begin
          expected_reads.push_back(timer_level(in_ch.paddle_index, in_ch.cycle_stamp));
        end
      end
    end
    outstanding <= expected_reads.size();
  end

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpt_pkg::*;

  localparam int NumPhases     = 10;      // random phases, each with its own settings
  localparam int PerPhase      = 55;      // random items per phase
  localparam int PressurePhase = 5;       // phase with the long result hold-off
  localparam int HoldCycles    = 300;
  localparam int MaxGap        = 18;
  localparam int DrainCycles   = 8;       // lets a trailing trigger leave the pipeline, with plenty of slack
  localparam int CycleLimit    = 200000;
  localparam int MaxRun  = int'(PadMaxValue) * int'(CyclesPerStep);
  localparam int FullRun = int'(PadFull) * int'(CyclesPerStep);

  typedef struct packed {
    logic swap;
    logic invert;
    pos_t margin_left;
    pos_t margin_top;
  } paddle_cfg_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  int     mismatches;
  int     outstanding;
  longint cycles = 0;

  // Idle switches per phase, and the request for one long result stall
  bit     in_idle;
  bit     out_idle;
  bit     hold_request = 1'b0;

  // Stimulus bookkeeping: the most recent trigger stamp and a running machine time,
  // so that most reads land inside or near the live timer window
  stamp_t last_trigger = '0;
  stamp_t clock_now = '0;

  gpt_in_if  in_ch ();
  gpt_out_if out_ch ();
  gpt_cfg_if cfg_ch ();

  game_paddle_timer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  paddle_check u_check (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a missing result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // At least half the draws are zero so back-to-back stretches occur even with idling on
  function automatic int draw_gap(bit idle_on);
    if (!idle_on) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  // Position or margin: corners often, otherwise uniform up to span
  function automatic pos_t pick_pos(int span);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pos_t'($urandom_range(0, span));
    endcase
  endfunction

  // Offer one item. Valid stays high from the previous item unless a gap is drawn,
  // so there is never a low-then-high pair in the same step. Ready is sampled at the
  // falling edge, where everything driven at the rising edge has settled.
  task automatic send_access(logic op, stamp_t stamp, logic [1:0] idx, pos_t mx, pos_t my);
    int gap;
    bit taken;
    gap = draw_gap(in_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.cycle_stamp  <= stamp;
    in_ch.paddle_index <= idx;
    in_ch.mouse_x      <= mx;
    in_ch.mouse_y      <= my;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stop offering, wait for every pending read to come back, then let the
  // pipeline empty of any trailing trigger.
  task automatic settle();
    in_ch.valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (outstanding == 0) break;
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [9:0] data);
    bit taken;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // All four registers in one burst; valid drops only after the last write
  task automatic write_settings(paddle_cfg_t s);
    put_reg(CfgSwapPairs, {9'b0, s.swap});
    put_reg(CfgInvertValues, {9'b0, s.invert});
    put_reg(CfgMarginLeft, s.margin_left);
    put_reg(CfgMarginTop, s.margin_top);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random item. About a fifth are triggers; most reads aim at the window
  // around the last trigger so both running and done answers show up, a few
  // carry a stamp from anywhere in the 48-bit range.
  task automatic random_access();
    int     pick;
    longint offset;
    stamp_t stamp;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 3))
        0: stamp = stamp_t'({$urandom, $urandom});
        1: stamp = stamp_t'('1) - stamp_t'($urandom_range(0, 3000));
        default: begin
          clock_now = clock_now + stamp_t'($urandom_range(1, 5000));
          stamp = clock_now;
        end
      endcase
      last_trigger = stamp;
      send_access(OpTrigger, stamp, 2'($urandom_range(0, 3)), pick_pos(1023), pick_pos(1023));
    end else begin
      if (pick < 28) begin
        stamp = stamp_t'({$urandom, $urandom});
      end else begin
        offset = longint'($urandom_range(0, 3500)) - 400;
        stamp  = last_trigger + stamp_t'(offset);
      end
      send_access(OpRead, stamp, 2'($urandom_range(0, 3)), pick_pos(1023), pick_pos(1023));
    end
  endtask

  // Result side: a random stall before each result, or one long hold-off on request
  initial begin : result_sink
    int stall;
    bit taken;
    out_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = HoldCycles;
        hold_request = 1'b0;
      end else begin
        stall = draw_gap(out_idle);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_ch.valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin : stimulus
    paddle_cfg_t s;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OpTrigger;
    in_ch.cycle_stamp  <= '0;
    in_ch.paddle_index <= '0;
    in_ch.mouse_x      <= '0;
    in_ch.mouse_y      <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CfgSwapPairs;
    cfg_ch.data        <= '0;
    in_idle  = 1'b0;
    out_idle = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // ---- directed, reset settings, items back to back ----
    // untouched state: trigger time 0, all paddles 0, so stamp 0 is already done
    send_access(OpRead, '0, 2'd0, '0, '0);
    // mouse in the far corner: both axes clamp at the maximum value
    send_access(OpTrigger, stamp_t'(1000), 2'd3, 10'd1023, 10'd1023);
    send_access(OpRead, stamp_t'(1000 + MaxRun - 1), 2'd0, '0, '0);   // last running stamp
    send_access(OpRead, stamp_t'(1000 + MaxRun), 2'd0, '0, '0);       // first done stamp
    send_access(OpRead, stamp_t'(1000 + MaxRun - 1), 2'd1, '0, '0);
    send_access(OpRead, stamp_t'(1000 + FullRun - 1), 2'd2, '0, '0);  // fixed paddles
    send_access(OpRead, stamp_t'(1000 + FullRun), 2'd3, '0, '0);
    // stamp earlier than the trigger
    send_access(OpRead, stamp_t'(999), 2'd1, '0, '0);
    // trigger at the top of the stamp range, mouse at the origin
    send_access(OpTrigger, '1, 2'd0, '0, '0);
    send_access(OpRead, '1, 2'd0, '0, '0);
    send_access(OpRead, 48'hFFFF_FFFF_FFFE, 2'd1, '0, '0);
    send_access(OpRead, '0, 2'd3, '0, '0);
    // one step of mouse travel scales down to zero; read right behind the trigger
    send_access(OpTrigger, '0, 2'd3, 10'd1, 10'd1);
    send_access(OpRead, '0, 2'd0, '0, '0);
    // mid-range position on both axes
    send_access(OpTrigger, stamp_t'(5000), 2'd0, 10'd560, 10'd377);
    send_access(OpRead, stamp_t'(5000 + FullRun - 1), 2'd0, '0, '0);

    // ---- directed: swapped pairs and inverted values ----
    settle();
    write_settings('{swap: 1'b1, invert: 1'b1, margin_left: '0, margin_top: '0});
    send_access(OpTrigger, stamp_t'(10000), 2'd0, 10'd1023, 10'd600);
    // an inverted clamped value goes negative: the timer ends before the trigger
    send_access(OpRead, stamp_t'(10000 - 276), 2'd1, '0, '0);
    send_access(OpRead, stamp_t'(10000 - 275), 2'd1, '0, '0);
    send_access(OpRead, stamp_t'(10000), 2'd0, '0, '0);
    send_access(OpRead, stamp_t'(9999), 2'd2, '0, '0);
    send_access(OpRead, stamp_t'(10000), 2'd3, '0, '0);

    // ---- directed: full margins, mouse at or below them gives zero ----
    settle();
    write_settings('{swap: 1'b0, invert: 1'b0, margin_left: '1, margin_top: '1});
    send_access(OpTrigger, stamp_t'(20), 2'd0, 10'd1023, 10'd1023);
    send_access(OpRead, stamp_t'(19), 2'd0, '0, '0);
    send_access(OpRead, stamp_t'(20), 2'd1, '0, '0);

    // ---- random phases, fresh settings each; the first two are the extremes ----
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: s = '{swap: 1'b1, invert: 1'b1, margin_left: '1, margin_top: '1};
        1: s = '{swap: 1'b0, invert: 1'b0, margin_left: '0, margin_top: '0};
        default: begin
          s.swap        = 1'($urandom_range(0, 1));
          s.invert      = 1'($urandom_range(0, 1));
          s.margin_left = pick_pos(400);
          s.margin_top  = pick_pos(400);
        end
      endcase
      write_settings(s);
      in_idle  = (p % 3) != 1;
      out_idle = (p % 4) != 2;
      if (p == PressurePhase) begin
        // sender runs flat out while the result side holds off for a long stretch
        in_idle      = 1'b0;
        hold_request = 1'b1;
      end
      for (int n = 0; n < PerPhase; n++) random_access();
    end

    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
